FILE: rtl/tdq_pkg.sv
// Shared constants and types of the TPDF dither quantiser.
package tdq_pkg;

    // Input format and fixed-point alignment.
    localparam int INPUT_FRAC_BITS = 8;
    localparam int SAMPLE_W        = 32;
    localparam int GAIN_W          = 16;
    localparam int GAIN_FRAC       = 14;
    localparam int DITHER_W        = 16;
    localparam int DITHER_FRAC     = 16;
    localparam int PCM_W           = 16;
    localparam int PROD_W          = SAMPLE_W + GAIN_W + 1;
    localparam int PROD_FRAC       = INPUT_FRAC_BITS + GAIN_FRAC;
    localparam int SUM_FRAC        = (PROD_FRAC > DITHER_FRAC) ? PROD_FRAC : DITHER_FRAC;
    localparam int PROD_SHIFT      = SUM_FRAC - PROD_FRAC;
    localparam int DITHER_SHIFT    = SUM_FRAC - DITHER_FRAC;

    // Gain register reset value, about 0.7071 in Q2.14.
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11585;

    // Linear congruential generator, one step and two folded steps.
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam logic [31:0] LCG_SEED = 32'h1234_5678;
    localparam logic [31:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
    localparam logic [31:0] LCG_ADD2 = 32'(64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD));

    // Work item handed from the front end to the back end.
    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic [DITHER_W-1:0]      dither_a;
        logic [DITHER_W-1:0]      dither_b;
        logic                     end_of_block;
    } tdq_item_t;

endpackage

FILE: rtl/tdq_queue.sv
// Two-entry queue that decouples the front end from the back end.
module tdq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  tdq_pkg::tdq_item_t wr_item,
    output logic              full,
    input  logic              rd_en,
    output tdq_pkg::tdq_item_t rd_item,
    output logic              empty
);
    import tdq_pkg::*;

    tdq_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    // Status and pointer updates.
    always_comb
    begin
        full        = (count_reg == 2'd2);
        empty       = (count_reg == 2'd0);
        do_wr       = wr_en && !full;
        do_rd       = rd_en && !empty;
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/tdq_front.sv
// Front end: accepts samples, applies the gain and draws the dither values.
module tdq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                q_full,
    input  logic signed [tdq_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                end_of_block,
    input  logic                                cfg_we,
    input  logic [tdq_pkg::GAIN_W-1:0]          gain_scale,
    output logic                                q_push,
    output tdq_pkg::tdq_item_t                  q_item
);
    import tdq_pkg::*;

    logic [GAIN_W-1:0]          gain_reg;
    logic [31:0]                lcg_reg;
    logic [31:0]                lcg_next;
    logic [31:0]                draw1;
    logic signed [GAIN_W:0]     gain_signed;

    // Accept a transaction whenever the queue has room.
    assign q_push = push && !q_full;

    // Both LCG draws come straight from the current state, so the two steps
    // fold into one affine update of the state register.
    always_comb
    begin
        draw1       = lcg_reg * LCG_MUL + LCG_ADD;
        lcg_next    = lcg_reg * LCG_MUL2 + LCG_ADD2;
        gain_signed = signed'({1'b0, gain_reg});

        q_item.product      = PROD_W'(sample_in) * PROD_W'(gain_signed);
        q_item.dither_a     = draw1[23:8];
        q_item.dither_b     = lcg_next[23:8];
        q_item.end_of_block = end_of_block;
    end

    // Gain register and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            lcg_reg  <= LCG_SEED;
        end
        else
        begin
            if (cfg_we)
            begin
                gain_reg <= gain_scale;
            end
            if (q_push)
            begin
                lcg_reg <= lcg_next;
            end
        end
    end

endmodule

FILE: rtl/tdq_back.sv
// Back end: adds the dither, rounds half to even, saturates and holds the result.
module tdq_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  tdq_pkg::tdq_item_t               q_item,
    output logic                             q_pop,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [tdq_pkg::PCM_W-1:0] pcm_out,
    output logic                             end_of_block_out
);
    import tdq_pkg::*;

    localparam int SUM_W = PROD_W + PROD_SHIFT + 1;
    localparam int QW    = SUM_W - SUM_FRAC;

    localparam logic [SUM_FRAC-1:0] HALF    = {1'b1, {(SUM_FRAC-1){1'b0}}};
    localparam logic signed [QW:0]  PCM_MAX = (QW+1)'(32767);
    localparam logic signed [QW:0]  PCM_MIN = -(QW+1)'(32768);

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [PCM_W-1:0]   pcm_reg;
    logic signed [PCM_W-1:0]   pcm_next;
    logic                      eob_reg;
    logic signed [DITHER_W:0]  dither;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   dith_ext;
    logic signed [SUM_W-1:0]   sum;
    logic signed [QW-1:0]      quot;
    logic [SUM_FRAC-1:0]       rem;
    logic                      round_up;
    logic signed [QW:0]        rounded;

    // Take the queue head whenever the output stage is free or being emptied.
    assign q_pop = !q_empty && (!out_valid_reg || pop);

    // Exact sum, floor quotient, ties-to-even rounding and saturation.
    always_comb
    begin
        dither   = signed'({1'b0, q_item.dither_a}) - signed'({1'b0, q_item.dither_b});
        prod_ext = SUM_W'(q_item.product) <<< PROD_SHIFT;
        dith_ext = SUM_W'(dither) <<< DITHER_SHIFT;
        sum      = prod_ext + dith_ext;
        quot     = sum[SUM_W-1:SUM_FRAC];
        rem      = sum[SUM_FRAC-1:0];
        round_up = (rem > HALF) || ((rem == HALF) && quot[0]);
        rounded  = (QW+1)'(quot) + signed'({{QW{1'b0}}, round_up});
        if (rounded > PCM_MAX)
        begin
            pcm_next = PCM_W'(PCM_MAX);
        end
        else if (rounded < PCM_MIN)
        begin
            pcm_next = PCM_W'(PCM_MIN);
        end
        else
        begin
            pcm_next = rounded[PCM_W-1:0];
        end

        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Output stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pcm_reg <= pcm_next;
            eob_reg <= q_item.end_of_block;
        end
    end

    assign empty            = !out_valid_reg;
    assign pcm_out          = pcm_reg;
    assign end_of_block_out = eob_reg;

endmodule

FILE: rtl/tpdf_dither_quantizer.sv
// Top level of the TPDF dither quantiser.
//
// Usage:
// The input side is a queue write port: a transaction is taken at a rising
// edge with push high and full low, carrying sample_in (signed, eight
// fractional bits) and end_of_block. The result side is a queue read port:
// while empty is low, pcm_out and end_of_block_out show the oldest result,
// which is removed at a rising edge with pop high.
// Each sample is scaled by gain_scale (Q2.14), triangular dither is added,
// and the sum is rounded half to even and saturated to 16 bits.
// gain_scale is loaded at any edge with cfg_we high; change it only when idle.
// Flow: a result passes through a queue entry and then the output register
// before it shows on the outputs. One sample is accepted every cycle while
// full is low; the front end's two parallel LCG multipliers advance the
// generator by two draws in a single update.
// Reset: the gain returns to about 0.7071, the generator to its seed, and
// the queue and the output register are emptied.
// Stalls: when pop is held low the result holds; the two-entry queue between
// front and back end absorbs two more samples before full rises.
module tpdf_dither_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [tdq_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                end_of_block,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tdq_pkg::PCM_W-1:0]    pcm_out,
    output logic                                end_of_block_out,
    input  logic                                cfg_we,
    input  logic [tdq_pkg::GAIN_W-1:0]          gain_scale
);
    import tdq_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    tdq_item_t wr_item;
    tdq_item_t rd_item;

    assign full = q_full;

    // Front end.
    tdq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (q_full),
        .sample_in    (sample_in),
        .end_of_block (end_of_block),
        .cfg_we       (cfg_we),
        .gain_scale   (gain_scale),
        .q_push       (q_push),
        .q_item       (wr_item)
    );

    // Decoupling queue.
    tdq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // Back end.
    tdq_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_item           (rd_item),
        .q_pop            (q_pop),
        .empty            (empty),
        .pop              (pop),
        .pcm_out          (pcm_out),
        .end_of_block_out (end_of_block_out)
    );

endmodule

FILE: rtl/tdq_checker.sv
// Port-level checker for the TPDF dither quantiser, bound to the top level.
module tdq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] pcm_out,
    input logic        end_of_block_out
);

    // Reset leaves no result waiting.
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result present after reset");

    // Reset leaves room for input.
    assert property (@(posedge clk) !rst_n |=> !full)
        else $error("input blocked after reset");

    // Input back-pressure only arises behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
        else $error("full raised with no result waiting");

    // A result that is not taken stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pcm_out) && $stable(end_of_block_out)))
        else $error("waiting result changed before it was taken");

endmodule

bind tpdf_dither_quantizer tdq_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .pcm_out          (pcm_out),
    .end_of_block_out (end_of_block_out)
);

FILE: bench/testbench.sv
// Self-checking testbench for the TPDF dither quantiser.
module testbench;
    import tdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam logic [SUM_FRAC-1:0] ROUND_HALF = {1'b1, {(SUM_FRAC-1){1'b0}}};
    localparam longint PCM_MAX = 32767;
    localparam longint PCM_MIN = -32768;

    typedef struct {
        logic signed [PCM_W-1:0] pcm;
        logic                    eob;
    } pcm_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_block;
    logic                       empty;
    logic                       pop;
    logic signed [PCM_W-1:0]    pcm_out;
    logic                       end_of_block_out;
    logic                       cfg_we;
    logic [GAIN_W-1:0]          gain_scale;

    // Predictor state: generator and gain as the block should hold them.
    logic [31:0]       lcg_now;
    logic [GAIN_W-1:0] gain_now;
    pcm_result_t       pending_pcm[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests = 0;
    int mismatches = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int saturated_results = 0;
    int gain_writes = 0;
    int eob_count = 0;

    tpdf_dither_quantizer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sample_in        (sample_in),
        .end_of_block     (end_of_block),
        .empty            (empty),
        .pop              (pop),
        .pcm_out          (pcm_out),
        .end_of_block_out (end_of_block_out),
        .cfg_we           (cfg_we),
        .gain_scale       (gain_scale)
    );

    // Free-running clock, 12 ns period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One step of the dither generator.
    function automatic logic [31:0] lcg_advance(input logic [31:0] x);
        return x * LCG_MUL + LCG_ADD;
    endfunction

    // Difference of the next two draws, in units of 2^-16 LSB.
    function automatic longint dither_offset(input logic [31:0] x);
        logic [31:0] x1;
        logic [31:0] x2;
        longint      da;
        longint      db;
        x1 = lcg_advance(x);
        x2 = lcg_advance(x1);
        da = longint'(x1[23:8]);
        db = longint'(x2[23:8]);
        return da - db;
    endfunction

    // Expected PCM for one accepted sample; advances the generator by two draws.
    function automatic pcm_result_t predict_pcm(input logic signed [SAMPLE_W-1:0] s,
                                                input logic eob);
        pcm_result_t         r;
        longint              sl;
        longint              gl;
        longint              acc;
        longint              q;
        logic [SUM_FRAC-1:0] frac;
        sl = longint'(s);
        gl = longint'(gain_now);
        acc = ((sl * gl) <<< PROD_SHIFT) + (dither_offset(lcg_now) <<< DITHER_SHIFT);
        lcg_now = lcg_advance(lcg_advance(lcg_now));
        q = acc >>> SUM_FRAC;
        frac = acc[SUM_FRAC-1:0];
        // Round to nearest, ties to the even integer.
        if (frac > ROUND_HALF || (frac == ROUND_HALF && q[0]))
            q = q + 1;
        if (q > PCM_MAX)
        begin
            q = PCM_MAX;
            saturated_results++;
        end
        else if (q < PCM_MIN)
        begin
            q = PCM_MIN;
            saturated_results++;
        end
        r.pcm = q[PCM_W-1:0];
        r.eob = eob;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one sample and hold it until the block takes it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eob);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        sample_in    <= s;
        end_of_block <= eob;
        do
            @(posedge clk);
        while (full);
        pending_pcm.push_back(predict_pcm(s, eob));
        samples_sent++;
        if (eob)
            eob_count++;
    endtask

    // Stop offering and let every expected result drain.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_pcm.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        wait_idle();
        @(negedge clk);
        cfg_we     <= 1'b1;
        gain_scale <= g;
        @(negedge clk);
        cfg_we <= 1'b0;
        gain_now = g;
        gain_writes++;
    endtask

    // Mix of full-range words, near-full-scale audio, quiet signals and extremes.
    function automatic logic signed [SAMPLE_W-1:0] rand_mix_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(3))
            0: s = $urandom;
            1: s = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: s = $signed($urandom_range(0, 4095)) - 2048;
            default:
            begin
                case ($urandom_range(3))
                    0: s = 32'sh7FFF_FFFF;
                    1: s = 32'sh8000_0000;
                    2: s = 32'sh007F_FF80;
                    default: s = -32'sh0080_0080;
                endcase
            end
        endcase
        return s;
    endfunction

    // Sample that lands exactly halfway above k after gain 1 and dither.
    function automatic logic signed [SAMPLE_W-1:0] tie_sample(input longint k);
        longint t;
        t = (k <<< SUM_FRAC) + (longint'(1) <<< (SUM_FRAC - 1))
            - (dither_offset(lcg_now) <<< DITHER_SHIFT);
        return t[SAMPLE_W-1:0];
    endfunction

    // Field extremes, saturation edges, zero gain and half-way rounding.
    task automatic test_directed();
        logic eob;
        eob = 1'b0;
        send_sample(32'sh0000_0000, eob);
        send_sample(-32'sh0000_0001, ~eob);
        send_sample(32'sh0000_0100, eob);
        send_sample(32'sh7FFF_FFFF, ~eob);
        send_sample(32'sh8000_0000, eob);
        send_sample(32'sh007F_FF80, ~eob);
        // Unity gain: sums close to the clipping points.
        write_gain(16'd16384);
        send_sample(32'sh007F_FF80, eob);
        send_sample(32'sh007F_FE80, ~eob);
        send_sample(-32'sh0080_0080, eob);
        send_sample(-32'sh007F_FF80, ~eob);
        send_sample(32'sh8000_0000, eob);
        // Largest gain drives both rails.
        write_gain(16'hFFFF);
        send_sample(32'sh7FFF_FFFF, ~eob);
        send_sample(32'sh8000_0000, eob);
        send_sample(32'sh0000_0001, ~eob);
        // Zero gain leaves only the dither.
        write_gain(16'd0);
        send_sample(32'sh7FFF_FFFF, eob);
        send_sample(32'sh8000_0000, ~eob);
        // Smallest gain lets exact halves be built against the known dither.
        write_gain(16'd1);
        for (longint k = -3; k <= 2; k++)
            send_sample(tie_sample(k), k[0]);
    endtask

    task automatic test_gain_extremes();
        logic [GAIN_W-1:0] gains[5];
        gains = '{16'd0, 16'hFFFF, 16'd16384, 16'd1, GAIN_RESET};
        foreach (gains[g])
        begin
            write_gain(gains[g]);
            repeat (80)
                send_sample(rand_mix_sample(), $urandom_range(7) == 0);
        end
    endtask

    task automatic test_random_samples(input int phases, input int per_phase);
        repeat (phases)
        begin
            write_gain(GAIN_W'($urandom_range(16'hFFFF)));
            repeat (per_phase)
                send_sample(rand_mix_sample(), $urandom_range(7) == 0);
        end
    endtask

    // The receiver stops for a long stretch while samples keep coming.
    task automatic test_backpressure();
        write_gain(GAIN_W'($urandom_range(16'hFFFF)));
        hold_requests++;
        repeat (40)
            send_sample(rand_mix_sample(), $urandom_range(7) == 0);
    endtask

    // Result side: pop at random, or not at all while a hold-off runs.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        pcm_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_pcm.size() == 0)
                report_mismatch($sformatf("unexpected result pcm_out=%0d", pcm_out));
            else
            begin
                want = pending_pcm.pop_front();
                results_checked++;
                if (pcm_out !== want.pcm)
                    report_mismatch($sformatf("pcm_out expected %0d, got %0d",
                                              want.pcm, pcm_out));
                if (end_of_block_out !== want.eob)
                    report_mismatch($sformatf("end_of_block_out expected %0b, got %0b",
                                              want.eob, end_of_block_out));
            end
        end
    end

    // Ends the run if neither side completes a transaction for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        sample_in    = '0;
        end_of_block = 1'b0;
        cfg_we       = 1'b0;
        gain_scale   = GAIN_RESET;
        lcg_now      = LCG_SEED;
        gain_now     = GAIN_RESET;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 78;
        test_directed();
        test_gain_extremes();

        send_idle_pct = 78;
        recv_idle_pct = 6;
        test_random_samples(4, 145);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_samples(5, 145);

        wait_idle();
        repeat (10) @(posedge clk);
        if (pending_pcm.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pcm.size()));

        $display("Sent %0d samples (%0d end-of-block marks) over %0d gain settings.",
                 samples_sent, eob_count, gain_writes + 1);
        $display("Checked %0d PCM results, %0d of them clipped, with %0d mismatches.",
                 results_checked, saturated_results, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
